// ----- design/hc_pkg.sv -----
// ----------------------------------------------------------------------------
// hc_pkg - shared types, constants and tables for the 2x2 Hill cipher block
// Alphabet size, derived widths, register indexes, reset key, the residue
// table for 5-bit letter codes, the modular inverse table and the helpers
// of the two-step modular reduction.
// ----------------------------------------------------------------------------
`default_nettype none

package hc_pkg;

	// Alphabet and derived widths
	localparam int ALPHABET_SIZE = 26;
	localparam int FIELD_W       = 5;                         // letter and key code width
	localparam int RES_W         = $clog2(ALPHABET_SIZE);     // residue width
	localparam int PROD_W        = 2 * RES_W;                 // residue times residue
	localparam int SUM_W         = 2 * RES_W + 1;             // sum of two products
	localparam int QUOT_W        = RES_W + 2;                 // quotient of a SUM_W value
	localparam int MOD_SQ        = ALPHABET_SIZE * ALPHABET_SIZE;

	// Reciprocal for the quotient estimate: floor(x * RECIP / 2^SHIFT) is q or q-1
	localparam int RED_SHIFT = 16;
	localparam int RED_RECIP = (1 << RED_SHIFT) / ALPHABET_SIZE;

	// Configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C0 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C1 = CFG_IDX_W'(3);

	// Identity key after reset
	localparam logic [FIELD_W-1:0] KEY_R0C0_RST = FIELD_W'(1);
	localparam logic [FIELD_W-1:0] KEY_R0C1_RST = FIELD_W'(0);
	localparam logic [FIELD_W-1:0] KEY_R1C0_RST = FIELD_W'(0);
	localparam logic [FIELD_W-1:0] KEY_R1C1_RST = FIELD_W'(1);

	// Stream widths
	localparam int TDATA_W = 16;

	// Operation codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef logic [RES_W-1:0] fld_tab_t [2**FIELD_W];
	typedef logic [RES_W-1:0] inv_tab_t [ALPHABET_SIZE];

	// Residue of every 5-bit code
	function automatic fld_tab_t build_fld_tab();
		fld_tab_t t;
		for (int i = 0; i < 2**FIELD_W; i++) begin
			t[i] = RES_W'(i % ALPHABET_SIZE);
		end
		return t;
	endfunction

	// Smallest inverse of every residue, zero where none exists
	function automatic inv_tab_t build_inv_tab();
		inv_tab_t t;
		for (int a = 0; a < ALPHABET_SIZE; a++) begin
			t[a] = '0;
			for (int i = ALPHABET_SIZE - 1; i >= 1; i--) begin
				if (((a * i) % ALPHABET_SIZE) == 1) begin
					t[a] = RES_W'(i);
				end
			end
		end
		return t;
	endfunction

	localparam fld_tab_t FLD_TAB = build_fld_tab();
	localparam inv_tab_t INV_TAB = build_inv_tab();

	// Quotient estimate of x by the alphabet size (exact or one short)
	function automatic logic [QUOT_W-1:0] quot_est(input logic [SUM_W-1:0] x);
		logic [SUM_W+RED_SHIFT-1:0] prod;
		prod = (SUM_W+RED_SHIFT)'(x) * (SUM_W+RED_SHIFT)'(RED_RECIP);
		return prod[RED_SHIFT +: QUOT_W];
	endfunction

	// Remainder from the estimate, with one correction step
	function automatic logic [RES_W-1:0] rem_fix(input logic [SUM_W-1:0] x,
			input logic [QUOT_W-1:0] q);
		logic [SUM_W-1:0] r;
		r = x - SUM_W'(q) * SUM_W'(ALPHABET_SIZE);
		if (r >= SUM_W'(ALPHABET_SIZE)) begin
			r = r - SUM_W'(ALPHABET_SIZE);
		end
		return RES_W'(r);
	endfunction

endpackage

`default_nettype wire

// ----- design/hill_cipher_2x2_mod26.sv -----
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26 - pipelined 2x2 Hill cipher on letter pairs
// Encrypts or decrypts one pair of letter codes per transaction with a
// programmable 2x2 key, modulo the alphabet size.
// ----------------------------------------------------------------------------
// One pair enters per clock and its result leaves from the last stage; the rate
// stays at one transaction per cycle while m_tready is high. The ten register
// stages are: operand reduction, key products, determinant quotient,
// determinant residue, inverse lookup and row products, row sum quotient,
// row sum residue, scaling by the inverse determinant, scaled quotient and
// scaled residue. Each stage holds its transaction only while the next one
// is full and blocked, so empty stages keep taking input while a result waits
// at the output. Decrypt with a key whose determinant has no inverse returns
// zero letters and sets m_tuser. Write the key only while no transaction is
// in flight.
`default_nettype none

module hill_cipher_2x2_mod26 (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [hc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hc_pkg::FIELD_W-1:0]      cfg_data,
	// input pairs
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [hc_pkg::TDATA_W-1:0]      s_tdata,  // [4:0] first_letter, [9:5] second_letter
	input  wire logic                            s_tuser,  // [0] operation
	// results
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [hc_pkg::TDATA_W-1:0]           m_tdata,  // [4:0] first_out, [9:5] second_out
	output logic                                 m_tuser   // [0] key_not_invertible
);

	localparam int NSTG = 10;
	localparam int RW   = hc_pkg::RES_W;
	localparam int PW   = hc_pkg::PROD_W;
	localparam int SW   = hc_pkg::SUM_W;
	localparam int QW   = hc_pkg::QUOT_W;
	localparam int FW   = hc_pkg::FIELD_W;

	// Key registers
	logic [FW-1:0] key00_q, key01_q, key10_q, key11_q;
	logic [RW-1:0] kr00, kr01, kr10, kr11;

	// Pipeline control
	logic [NSTG:1] vld_q;
	logic [NSTG:1] rdy;

	// Stage payload
	logic          op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7, op_s8, op_s9, op_s10;
	logic [RW-1:0] p0_s1, p1_s1, p0_s2, p1_s2, p0_s3, p1_s3, p0_s4, p1_s4;
	logic [PW-1:0] ad_s2, bc_s2;
	logic [SW-1:0] dx_s3;
	logic [QW-1:0] dq_s3;
	logic [RW-1:0] det_s4;
	logic          err_s5, err_s6, err_s7, err_s8, err_s9, err_s10;
	logic [RW-1:0] g_s5, g_s6, g_s7;
	logic [SW-1:0] t0_s5, t1_s5, t0_s6, t1_s6;
	logic [QW-1:0] tq0_s6, tq1_s6;
	logic [RW-1:0] tr0_s7, tr1_s7;
	logic [PW-1:0] u0_s8, u1_s8, u0_s9, u1_s9;
	logic [QW-1:0] uq0_s9, uq1_s9;
	logic [RW-1:0] res0_s10, res1_s10;

	// Stage combinational values
	logic [SW-1:0] dx_d;
	logic [RW-1:0] inv_d, nb_d, nc_d;
	logic [RW-1:0] m00_d, m01_d, m10_d, m11_d;

	// Configuration: always ready, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key00_q <= hc_pkg::KEY_R0C0_RST;
			key01_q <= hc_pkg::KEY_R0C1_RST;
			key10_q <= hc_pkg::KEY_R1C0_RST;
			key11_q <= hc_pkg::KEY_R1C1_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hc_pkg::REG_KEY_R0C0: key00_q <= cfg_data;
				hc_pkg::REG_KEY_R0C1: key01_q <= cfg_data;
				hc_pkg::REG_KEY_R1C0: key10_q <= cfg_data;
				hc_pkg::REG_KEY_R1C1: key11_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Reduced key; the user keeps it stable while transactions are in flight, the block does not enforce it
	assign kr00 = hc_pkg::FLD_TAB[key00_q];
	assign kr01 = hc_pkg::FLD_TAB[key01_q];
	assign kr10 = hc_pkg::FLD_TAB[key10_q];
	assign kr11 = hc_pkg::FLD_TAB[key11_q];

	// Ready chain: a stage loads when empty or when its successor moves
	always_comb begin
		rdy[NSTG] = !vld_q[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_tready = rdy[1];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: reduce letter codes
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			op_s1 <= s_tuser;
			p0_s1 <= hc_pkg::FLD_TAB[s_tdata[FW-1:0]];
			p1_s1 <= hc_pkg::FLD_TAB[s_tdata[2*FW-1:FW]];
		end
	end

	// Stage 2: determinant products
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			op_s2 <= op_s1;
			p0_s2 <= p0_s1;
			p1_s2 <= p1_s1;
			ad_s2 <= PW'(kr00) * PW'(kr11);
			bc_s2 <= PW'(kr01) * PW'(kr10);
		end
	end

	// Stage 3: non-negative determinant and its quotient estimate
	assign dx_d = SW'(ad_s2) + SW'(hc_pkg::MOD_SQ) - SW'(bc_s2);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			op_s3 <= op_s2;
			p0_s3 <= p0_s2;
			p1_s3 <= p1_s2;
			dx_s3 <= dx_d;
			dq_s3 <= hc_pkg::quot_est(dx_d);
		end
	end

	// Stage 4: determinant residue
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			op_s4  <= op_s3;
			p0_s4  <= p0_s3;
			p1_s4  <= p1_s3;
			det_s4 <= hc_pkg::rem_fix(dx_s3, dq_s3);
		end
	end

	// Stage 5: inverse lookup, adjugate or key rows, row products
	assign inv_d = hc_pkg::INV_TAB[det_s4];
	assign nb_d  = (kr01 == '0) ? '0 : RW'(hc_pkg::ALPHABET_SIZE - int'(kr01));
	assign nc_d  = (kr10 == '0) ? '0 : RW'(hc_pkg::ALPHABET_SIZE - int'(kr10));

	always_comb begin
		if (op_s4 == hc_pkg::OP_DECRYPT) begin
			m00_d = kr11;
			m01_d = nb_d;
			m10_d = nc_d;
			m11_d = kr00;
		end else begin
			m00_d = kr00;
			m01_d = kr01;
			m10_d = kr10;
			m11_d = kr11;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			op_s5  <= op_s4;
			err_s5 <= (op_s4 == hc_pkg::OP_DECRYPT) && (inv_d == '0);
			g_s5   <= (op_s4 == hc_pkg::OP_DECRYPT) ? inv_d : RW'(1);
			t0_s5  <= SW'(m00_d) * SW'(p0_s4) + SW'(m01_d) * SW'(p1_s4);
			t1_s5  <= SW'(m10_d) * SW'(p0_s4) + SW'(m11_d) * SW'(p1_s4);
		end
	end

	// Stage 6: row sum quotients
	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			op_s6  <= op_s5;
			err_s6 <= err_s5;
			g_s6   <= g_s5;
			t0_s6  <= t0_s5;
			t1_s6  <= t1_s5;
			tq0_s6 <= hc_pkg::quot_est(t0_s5);
			tq1_s6 <= hc_pkg::quot_est(t1_s5);
		end
	end

	// Stage 7: row sum residues
	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			op_s7  <= op_s6;
			err_s7 <= err_s6;
			g_s7   <= g_s6;
			tr0_s7 <= hc_pkg::rem_fix(t0_s6, tq0_s6);
			tr1_s7 <= hc_pkg::rem_fix(t1_s6, tq1_s6);
		end
	end

	// Stage 8: scale by the inverse determinant (one for encrypt)
	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			op_s8  <= op_s7;
			err_s8 <= err_s7;
			u0_s8  <= PW'(tr0_s7) * PW'(g_s7);
			u1_s8  <= PW'(tr1_s7) * PW'(g_s7);
		end
	end

	// Stage 9: scaled quotients
	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			op_s9  <= op_s8;
			err_s9 <= err_s8;
			u0_s9  <= u0_s8;
			u1_s9  <= u1_s8;
			uq0_s9 <= hc_pkg::quot_est(SW'(u0_s8));
			uq1_s9 <= hc_pkg::quot_est(SW'(u1_s8));
		end
	end

	// Stage 10: final residues, zero on error
	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			op_s10   <= op_s9;
			err_s10  <= err_s9;
			res0_s10 <= err_s9 ? '0 : hc_pkg::rem_fix(SW'(u0_s9), uq0_s9);
			res1_s10 <= err_s9 ? '0 : hc_pkg::rem_fix(SW'(u1_s9), uq1_s9);
		end
	end

	// Drive the result channel
	assign m_tvalid = vld_q[NSTG];
	assign m_tuser  = err_s10;
	assign m_tdata  = {(hc_pkg::TDATA_W - 2*FW)'(0), FW'(res1_s10), FW'(res0_s10)};

	// Assertions
	a_err_only_decrypt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (op_s10 == hc_pkg::OP_DECRYPT))
		else $error("error flag on an encrypt transaction");

	a_err_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("nonzero letters with error flag");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((int'(res0_s10) < hc_pkg::ALPHABET_SIZE) &&
			(int'(res1_s10) < hc_pkg::ALPHABET_SIZE)))
		else $error("result residue out of range");

	a_det_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[4] |-> (int'(det_s4) < hc_pkg::ALPHABET_SIZE))
		else $error("determinant residue out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

endmodule

`default_nettype wire

// ----- verif/hc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// hc_tb_pkg - result tracking for the 2x2 Hill cipher testbench
// Holds a copy of the key registers, works out the cipher result of every
// accepted letter pair, and compares returned results against them in order.
// ----------------------------------------------------------------------------
package hc_tb_pkg;

	import hc_pkg::*;

	// Index that maps to no key register
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

	typedef struct packed {
		logic               op;
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] second;
	} letter_pair_t;

	typedef struct packed {
		logic [FIELD_W-1:0] first_out;
		logic [FIELD_W-1:0] second_out;
		logic               not_inv;
	} cipher_res_t;

	class cipher_scoreboard;
		logic [FIELD_W-1:0] k00, k01, k10, k11;
		cipher_res_t        pending_q[$];
		int unsigned        mismatches;
		int unsigned        results_seen;
		int unsigned        n_encrypt;
		int unsigned        n_decrypt;
		int unsigned        n_singular;

		function new();
			k00 = KEY_R0C0_RST;
			k01 = KEY_R0C1_RST;
			k10 = KEY_R1C0_RST;
			k11 = KEY_R1C1_RST;
		endfunction

		// Track a key register write; unmapped indexes change nothing
		function void write_key(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
			case (idx)
				REG_KEY_R0C0: k00 = val;
				REG_KEY_R0C1: k01 = val;
				REG_KEY_R1C0: k10 = val;
				REG_KEY_R1C1: k11 = val;
				default: ;
			endcase
		endfunction

		// Encrypt with the key, or decrypt with its inverse modulo the alphabet
		function cipher_res_t cipher_pair(letter_pair_t p);
			int unsigned a, b, c, d, x0, x1, det, inv_det, i;
			int unsigned m00, m01, m10, m11;
			cipher_res_t r;
			a  = k00 % ALPHABET_SIZE;
			b  = k01 % ALPHABET_SIZE;
			c  = k10 % ALPHABET_SIZE;
			d  = k11 % ALPHABET_SIZE;
			x0 = p.first % ALPHABET_SIZE;
			x1 = p.second % ALPHABET_SIZE;
			r.not_inv = 1'b0;
			if (p.op == OP_ENCRYPT) begin
				m00 = a;
				m01 = b;
				m10 = c;
				m11 = d;
			end else begin
				// fold a negative determinant back into 0..N-1
				det = (a * d + ALPHABET_SIZE * ALPHABET_SIZE - b * c) % ALPHABET_SIZE;
				inv_det = 0;
				for (i = 1; i < ALPHABET_SIZE; i++) begin
					if (inv_det == 0 && (det * i) % ALPHABET_SIZE == 1) begin
						inv_det = i;
					end
				end
				if (inv_det == 0) begin
					r.not_inv = 1'b1;
					m00 = 0;
					m01 = 0;
					m10 = 0;
					m11 = 0;
				end else begin
					m00 = (d * inv_det) % ALPHABET_SIZE;
					m01 = (((ALPHABET_SIZE - b) % ALPHABET_SIZE) * inv_det) % ALPHABET_SIZE;
					m10 = (((ALPHABET_SIZE - c) % ALPHABET_SIZE) * inv_det) % ALPHABET_SIZE;
					m11 = (a * inv_det) % ALPHABET_SIZE;
				end
			end
			r.first_out  = FIELD_W'((m00 * x0 + m01 * x1) % ALPHABET_SIZE);
			r.second_out = FIELD_W'((m10 * x0 + m11 * x1) % ALPHABET_SIZE);
			return r;
		endfunction

		// Queue the result of an accepted pair
		function void note_pair(letter_pair_t p);
			cipher_res_t r;
			r = cipher_pair(p);
			if (p.op == OP_ENCRYPT) begin
				n_encrypt++;
			end else begin
				n_decrypt++;
			end
			if (r.not_inv) begin
				n_singular++;
			end
			pending_q.push_back(r);
		endfunction

		// Compare a returned result with the oldest pending one
		function void check_result(cipher_res_t got, longint unsigned now);
			cipher_res_t want;
			results_seen++;
			if (pending_q.size() == 0) begin
				mismatches++;
				$display("[%0d ns] unexpected result: expected none, actual %0d/%0d/%0b",
					now, got.first_out, got.second_out, got.not_inv);
				return;
			end
			want = pending_q.pop_front();
			if (got.first_out !== want.first_out) begin
				mismatches++;
				$display("[%0d ns] first_out: expected %0d, actual %0d",
					now, want.first_out, got.first_out);
			end
			if (got.second_out !== want.second_out) begin
				mismatches++;
				$display("[%0d ns] second_out: expected %0d, actual %0d",
					now, want.second_out, got.second_out);
			end
			if (got.not_inv !== want.not_inv) begin
				mismatches++;
				$display("[%0d ns] key_not_invertible: expected %0b, actual %0b",
					now, want.not_inv, got.not_inv);
			end
		endfunction
	endclass

endpackage

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench for the pipelined 2x2 Hill cipher
// Runs directed letter pairs over hand-picked keys (identity, negative and
// singular determinants, out-of-range codes), then random pairs over a series
// of random keys, with random stalls on both streams, and checks every result.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import hc_pkg::*;
	import hc_tb_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int RAND_PHASES    = 12;
	localparam int PAIRS_PER_PHASE = 150;
	localparam int TAIL_CYCLES    = 20;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIELD_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;   // [4:0] first_letter, [9:5] second_letter
	logic                 s_tuser;   // [0] operation
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;   // [4:0] first_out, [9:5] second_out
	logic                 m_tuser;   // [0] key_not_invertible

	cipher_scoreboard sb = new();

	bit          src_idle_en;
	bit          sink_idle_en;
	int unsigned sink_stall_left;
	int unsigned cycle_count;
	int unsigned key_settings;
	letter_pair_t in_pair;
	cipher_res_t  out_res;

	hill_cipher_2x2_mod26 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hill_cipher_2x2_mod26: mismatch");
			$finish;
		end
	end

	// Track key writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			sb.write_key(cfg_index, cfg_data);
		end
	end

	// Record accepted pairs
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			in_pair.op     = s_tuser;
			in_pair.first  = s_tdata[4:0];
			in_pair.second = s_tdata[9:5];
			sb.note_pair(in_pair);
		end
	end

	// Check results
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			out_res.first_out  = m_tdata[4:0];
			out_res.second_out = m_tdata[9:5];
			out_res.not_inv    = m_tuser;
			sb.check_result(out_res, $time);
		end
	end

	// Result side backpressure in random bursts
	always @(posedge clk) begin
		if (sink_stall_left != 0) begin
			m_tready <= 1'b0;
			sink_stall_left--;
		end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			sink_stall_left = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// One key register write transaction; the caller lowers cfg_valid
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Load a full key, optionally followed by a write to an unmapped index
	task automatic load_key(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
			logic [FIELD_W-1:0] c, logic [FIELD_W-1:0] d, bit stray_write);
		write_cfg(REG_KEY_R0C0, a);
		write_cfg(REG_KEY_R0C1, b);
		write_cfg(REG_KEY_R1C0, c);
		write_cfg(REG_KEY_R1C1, d);
		if (stray_write) begin
			write_cfg(REG_UNMAPPED, FIELD_W'($urandom_range(0, 31)));
		end
		cfg_valid <= 1'b0;
		key_settings++;
	endtask

	// Send one pair, with an occasional idle burst ahead of it
	task automatic send_pair(logic op, logic [FIELD_W-1:0] first, logic [FIELD_W-1:0] second);
		int unsigned gap;
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= TDATA_W'({second, first});
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold the input and wait until every pending result has come back
	task automatic hold_and_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	// Letter code, now and then one of the out-of-range codes
	function automatic logic [FIELD_W-1:0] rand_letter();
		if ($urandom_range(0, 15) == 0) begin
			return FIELD_W'($urandom_range(26, 31));
		end
		return FIELD_W'($urandom_range(0, 25));
	endfunction

	// Key element, biased toward the extremes
	function automatic logic [FIELD_W-1:0] rand_key_elem();
		case ($urandom_range(0, 11))
			0: return FIELD_W'(0);
			1: return FIELD_W'(25);
			2: return FIELD_W'(31);
			default: return FIELD_W'($urandom_range(0, 25));
		endcase
	endfunction

	// Stimulus
	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_ENCRYPT;
		m_tready  <= 1'b0;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity key out of reset
		send_pair(OP_ENCRYPT, 5'd0, 5'd25);
		send_pair(OP_DECRYPT, 5'd25, 5'd0);

		// invertible key, letter extremes and out-of-range codes
		hold_and_drain();
		load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
		send_pair(OP_ENCRYPT, 5'd0, 5'd0);
		send_pair(OP_ENCRYPT, 5'd25, 5'd25);
		send_pair(OP_DECRYPT, 5'd25, 5'd25);
		send_pair(OP_DECRYPT, 5'd0, 5'd25);
		send_pair(OP_ENCRYPT, 5'd31, 5'd26);
		send_pair(OP_DECRYPT, 5'd26, 5'd31);
		send_pair(OP_ENCRYPT, 5'd16, 5'd15);

		// determinant below zero before reduction
		hold_and_drain();
		load_key(5'd1, 5'd2, 5'd3, 5'd1, 1'b0);
		send_pair(OP_DECRYPT, 5'd7, 5'd19);
		send_pair(OP_ENCRYPT, 5'd25, 5'd1);
		send_pair(OP_DECRYPT, 5'd31, 5'd31);

		// singular key: decrypt flags, encrypt never does
		hold_and_drain();
		load_key(5'd2, 5'd4, 5'd1, 5'd3, 1'b0);
		send_pair(OP_DECRYPT, 5'd12, 5'd5);
		send_pair(OP_ENCRYPT, 5'd12, 5'd5);

		// all elements at the top of the range
		hold_and_drain();
		load_key(5'd25, 5'd25, 5'd25, 5'd25, 1'b0);
		send_pair(OP_DECRYPT, 5'd25, 5'd25);
		send_pair(OP_ENCRYPT, 5'd25, 5'd25);

		// key elements above the alphabet
		hold_and_drain();
		load_key(5'd31, 5'd0, 5'd0, 5'd27, 1'b1);
		send_pair(OP_ENCRYPT, 5'd31, 5'd31);
		send_pair(OP_DECRYPT, 5'd10, 5'd20);

		// all-zero key
		hold_and_drain();
		load_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
		send_pair(OP_ENCRYPT, 5'd9, 5'd9);
		send_pair(OP_DECRYPT, 5'd9, 5'd9);

		// random keys and pairs; the last phases run without idling
		for (int p = 0; p < RAND_PHASES; p++) begin
			hold_and_drain();
			load_key(rand_key_elem(), rand_key_elem(), rand_key_elem(), rand_key_elem(),
				$urandom_range(0, 3) == 0);
			src_idle_en  = (p < RAND_PHASES - 2) && (p % 3 != 1);
			sink_idle_en = (p < RAND_PHASES - 2) && (p % 3 != 2);
			for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
				if (p == 4 && n == PAIRS_PER_PHASE / 2) begin
					hold_and_drain();
				end
				send_pair($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT,
					rand_letter(), rand_letter());
			end
		end

		// let the pipeline empty, then watch for stray results
		hold_and_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d encrypt and %0d decrypt pairs over %0d key settings",
			sb.n_encrypt, sb.n_decrypt, key_settings);
		$display("%0d decrypts met a singular key, %0d results checked",
			sb.n_singular, sb.results_seen);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("hill_cipher_2x2_mod26: match");
		end else begin
			$display("hill_cipher_2x2_mod26: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/hc_pkg.sv
design/hill_cipher_2x2_mod26.sv
verif/hc_tb_pkg.sv
verif/tb_top.sv
